// ----- src/pwt_pkg.sv -----
package pwt_pkg;

    localparam int INDEX_BITS_DEF = 9;
    localparam int PAGE_SHIFT     = 12;
    localparam int LARGE_BIT      = 7;
    localparam int VADDR_W        = 48;
    localparam int ADDR_W         = 64;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 64;

    localparam logic [ADDR_W-1:0] ROOT_MASK       = 64'hFFFF_FFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] ENTRY_MASK_INIT = 64'h000F_FFFF_FFFF_F000;

    // Register select bit of paddr: registers sit 8 bytes apart
    localparam int REG_SEL_BIT = 3;

    typedef enum logic {
        REG_TABLE_ROOT = 1'b0,
        REG_ENTRY_MASK = 1'b1
    } t_reg_sel;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_RESP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2
    } t_page_size;

    typedef enum logic [1:0] {
        LVL_IDLE   = 2'd0,
        LVL_TOP    = 2'd1,
        LVL_SECOND = 2'd2,
        LVL_THIRD  = 2'd3
    } t_level;

    typedef struct packed {
        t_cmd                cmd;
        logic [VADDR_W-1:0]  vaddr;
        logic [ADDR_W-1:0]   read_data;
    } t_in_item;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   entry_addr;
        t_page_size          page_size;
    } t_out_item;

    typedef struct packed {
        t_level              level;
        logic [VADDR_W-1:0]  saved_vaddr;
        logic [ADDR_W-1:0]   pending_addr;
    } t_walk_state;

endpackage

// ----- src/pwt_step.sv -----
module pwt_step #(
    parameter int INDEX_BITS = pwt_pkg::INDEX_BITS_DEF
) (
    input  pwt_pkg::t_in_item                i_item,
    input  pwt_pkg::t_walk_state             i_state,
    input  logic [pwt_pkg::ADDR_W-1:0]       i_table_root,
    input  logic [pwt_pkg::ADDR_W-1:0]       i_entry_mask,
    output pwt_pkg::t_out_item               o_result,
    output pwt_pkg::t_walk_state             o_state
);
    import pwt_pkg::*;

    localparam int LEVELS = 4;

    logic [INDEX_BITS-1:0] w_idx [LEVELS];
    logic [INDEX_BITS-1:0] w_idx_sel;
    logic [ADDR_W-1:0]     w_base;
    logic [ADDR_W-1:0]     w_base_sel;
    logic [ADDR_W-1:0]     w_entry_addr;
    logic                  w_large;
    logic                  w_start_ok;

    assign w_base     = i_item.read_data & i_entry_mask;
    assign w_large    = i_item.read_data[LARGE_BIT];
    assign w_start_ok = (i_item.cmd == CMD_START) && (i_state.level == LVL_IDLE);

    // Index of each level; the top index comes from the new address on a start
    always_comb begin
        for (int k = 0; k < LEVELS; k++) begin
            if (k == 0) begin
                w_idx[k] = INDEX_BITS'(i_item.vaddr >>
                           (PAGE_SHIFT + INDEX_BITS * (LEVELS - 1)));
            end else begin
                w_idx[k] = INDEX_BITS'(i_state.saved_vaddr >>
                           (PAGE_SHIFT + INDEX_BITS * (LEVELS - 1 - k)));
            end
        end
    end

    always_comb begin
        w_base_sel = w_base;
        w_idx_sel  = w_idx[0];
        unique case (i_state.level)
            LVL_IDLE: begin
                w_base_sel = i_table_root & ROOT_MASK;
                w_idx_sel  = w_idx[0];
            end
            LVL_TOP:    w_idx_sel = w_idx[1];
            LVL_SECOND: w_idx_sel = w_idx[2];
            LVL_THIRD:  w_idx_sel = w_idx[3];
            default:    w_idx_sel = w_idx[0];
        endcase
    end

    assign w_entry_addr = w_base_sel + ADDR_W'({w_idx_sel, 3'b000});

    // Next state
    always_comb begin
        o_state = i_state;
        if (i_item.cmd == CMD_START) begin
            if (w_start_ok) begin
                o_state.level        = LVL_TOP;
                o_state.saved_vaddr  = i_item.vaddr;
                o_state.pending_addr = w_entry_addr;
            end
        end else begin
            unique case (i_state.level)
                LVL_IDLE: o_state = i_state;
                LVL_TOP: begin
                    o_state.level        = LVL_SECOND;
                    o_state.pending_addr = w_entry_addr;
                end
                LVL_SECOND: begin
                    if (w_large) begin
                        o_state.level = LVL_IDLE;
                    end else begin
                        o_state.level        = LVL_THIRD;
                        o_state.pending_addr = w_entry_addr;
                    end
                end
                LVL_THIRD: begin
                    o_state.level = LVL_IDLE;
                    if (!w_large) begin
                        o_state.pending_addr = w_entry_addr;
                    end
                end
                default: o_state = i_state;
            endcase
        end
    end

    // Result
    always_comb begin
        o_result.kind       = KIND_ERROR;
        o_result.entry_addr = '0;
        o_result.page_size  = SIZE_4K;
        if (i_item.cmd == CMD_START) begin
            if (w_start_ok) begin
                o_result.kind       = KIND_READ;
                o_result.entry_addr = w_entry_addr;
            end
        end else begin
            unique case (i_state.level)
                LVL_IDLE: o_result.kind = KIND_ERROR;
                LVL_TOP: begin
                    o_result.kind       = KIND_READ;
                    o_result.entry_addr = w_entry_addr;
                end
                LVL_SECOND: begin
                    if (w_large) begin
                        o_result.kind       = KIND_DONE;
                        o_result.entry_addr = i_state.pending_addr;
                        o_result.page_size  = SIZE_1G;
                    end else begin
                        o_result.kind       = KIND_READ;
                        o_result.entry_addr = w_entry_addr;
                    end
                end
                LVL_THIRD: begin
                    o_result.kind = KIND_DONE;
                    if (w_large) begin
                        o_result.entry_addr = i_state.pending_addr;
                        o_result.page_size  = SIZE_2M;
                    end else begin
                        // last-level entry is not read, only located
                        o_result.entry_addr = w_entry_addr;
                    end
                end
                default: o_result.kind = KIND_ERROR;
            endcase
        end
    end

endmodule

// ----- src/page_table_walker_top.sv -----
// Channel   Direction  Signals                              Transfer when
// in        input      i_in_valid, o_in_stall, i_in_item    valid high, stall low
// out       output     o_out_valid, i_out_stall, o_out_item valid high, stall low
// cfg       input      psel, penable, pwrite, paddr, pwdata  psel, penable, pwrite
//
// One item per cycle while o_in_stall is low; each item yields one result, registered into the output
// register, or into the skid register when the output is stalled. The walk state updates as the item is
// taken, and o_in_stall rises only while the skid register is full.
// Synchronous active-low reset empties the output and skid registers, clears
// the walk state and loads the register reset values.
module page_table_walker_top #(
    parameter int INDEX_BITS = pwt_pkg::INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pwt_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pwt_pkg::t_out_item               o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pwt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pwt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pwt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import pwt_pkg::*;

    logic [ADDR_W-1:0] r_table_root;
    logic [ADDR_W-1:0] r_entry_mask;
    t_walk_state       r_state;
    t_walk_state       w_state_next;
    t_out_item         w_result;
    t_out_item         r_out;
    t_out_item         n_out;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_skid;
    t_out_item         n_skid;
    logic              r_skid_valid;
    logic              n_skid_valid;
    logic              w_accept;
    logic              w_take;
    logic              w_cfg_write;
    t_reg_sel          w_reg_sel;

    assign pready      = 1'b1;
    assign w_reg_sel   = t_reg_sel'(paddr[REG_SEL_BIT]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_sel)
            REG_TABLE_ROOT: prdata = r_table_root;
            REG_ENTRY_MASK: prdata = r_entry_mask;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_root <= '0;
            r_entry_mask <= ENTRY_MASK_INIT;
        end else if (w_cfg_write) begin
            if (w_reg_sel == REG_TABLE_ROOT) begin
                r_table_root <= pwdata;
            end else begin
                r_entry_mask <= pwdata;
            end
        end
    end

    pwt_step #(
        .INDEX_BITS (INDEX_BITS)
    ) u_step (
        .i_item       (i_in_item),
        .i_state      (r_state),
        .i_table_root (r_table_root),
        .i_entry_mask (r_entry_mask),
        .o_result     (w_result),
        .o_state      (w_state_next)
    );

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level        <= LVL_IDLE;
            r_state.saved_vaddr  <= '0;
            r_state.pending_addr <= '0;
        end else if (w_accept) begin
            r_state <= w_state_next;
        end
    end

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (w_take) begin
            if (r_skid_valid) begin
                // drain the skid first; no transfer in while it is full
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_result;
                n_out_valid = w_accept;
            end
        end else if (w_accept) begin
            if (!r_out_valid) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

// ----- src/pwt_checker.sv -----
module pwt_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  pwt_pkg::t_out_item  o_out_item
);
    import pwt_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Input stalls only while a result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_read_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_READ |-> o_out_item.page_size == SIZE_4K)
        else $error("read request with page size");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_ERROR
            |-> o_out_item.entry_addr == '0 && o_out_item.page_size == SIZE_4K)
        else $error("error result with payload");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

endmodule

bind page_table_walker_top pwt_checker u_pwt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- tb/page_table_walker_top_tb.sv -----
module page_table_walker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwt_pkg::*;

    localparam int          IDX_W       = INDEX_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Walker state and registers as the block should hold them
    t_level                walk_lvl        = LVL_IDLE;
    logic [VADDR_W-1:0]    walk_vaddr      = '0;
    logic [ADDR_W-1:0]     walk_entry_addr = '0;
    logic [ADDR_W-1:0]     root_reg        = '0;
    logic [ADDR_W-1:0]     mask_reg        = ENTRY_MASK_INIT;

    t_out_item             expected_results[$];
    int unsigned           item_count  = 0;
    int unsigned           burst_left  = 0;
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;

    page_table_walker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("page_table_walker_top_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] table_entry_addr(logic [ADDR_W-1:0] base,
                                                           int unsigned lvl);
        logic [ADDR_W-1:0] idx;
        idx = ADDR_W'(walk_vaddr >> (PAGE_SHIFT + IDX_W * (3 - lvl)))
              & ((ADDR_W'(1) << IDX_W) - 1);
        return base + (idx << 3);
    endfunction

    // Advance the walk by one accepted item and return the result it must give
    function automatic t_out_item walk_step(t_in_item it);
        t_out_item         r;
        logic [ADDR_W-1:0] base;
        logic              big;
        r = '{kind: KIND_ERROR, entry_addr: '0, page_size: SIZE_4K};
        if (it.cmd == CMD_START) begin
            if (walk_lvl == LVL_IDLE) begin
                walk_vaddr      = it.vaddr;
                walk_entry_addr = table_entry_addr(root_reg & ROOT_MASK, 0);
                walk_lvl        = LVL_TOP;
                r.kind          = KIND_READ;
                r.entry_addr    = walk_entry_addr;
            end
        end else if (walk_lvl != LVL_IDLE) begin
            base = it.read_data & mask_reg;
            big  = it.read_data[LARGE_BIT];
            case (walk_lvl)
                LVL_TOP: begin
                    walk_entry_addr = table_entry_addr(base, 1);
                    walk_lvl        = LVL_SECOND;
                    r.kind          = KIND_READ;
                    r.entry_addr    = walk_entry_addr;
                end
                LVL_SECOND: begin
                    if (big) begin
                        walk_lvl     = LVL_IDLE;
                        r.kind       = KIND_DONE;
                        r.entry_addr = walk_entry_addr;
                        r.page_size  = SIZE_1G;
                    end else begin
                        walk_entry_addr = table_entry_addr(base, 2);
                        walk_lvl        = LVL_THIRD;
                        r.kind          = KIND_READ;
                        r.entry_addr    = walk_entry_addr;
                    end
                end
                default: begin
                    walk_lvl = LVL_IDLE;
                    r.kind   = KIND_DONE;
                    if (big) begin
                        r.entry_addr = walk_entry_addr;
                        r.page_size  = SIZE_2M;
                    end else begin
                        walk_entry_addr = table_entry_addr(base, 3);
                        r.entry_addr    = walk_entry_addr;
                        r.page_size     = SIZE_4K;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VADDR_W-1:0] rand_vaddr();
        return VADDR_W'({$urandom, $urandom});
    endfunction

    // Random entry; now and then push the base near the top to wrap address sums
    function automatic logic [ADDR_W-1:0] rand_entry();
        logic [ADDR_W-1:0] d;
        d = rand64();
        if ($urandom_range(0, 7) == 0) d = d | 64'hFFFF_FFFF_FFFF_F000;
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_with(logic big);
        logic [ADDR_W-1:0] d;
        d            = rand_entry();
        d[LARGE_BIT] = big;
        return d;
    endfunction

    // Receiver: stall pattern switches between calm, light, heavy and blocked stretches
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ($urandom_range(0, 11) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item exp;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with none expected: kind %0d entry_addr %h page_size %0d",
                       out_item.kind, out_item.entry_addr, out_item.page_size);
                error_count++;
            end else begin
                exp = expected_results.pop_front();
                if (out_item.kind !== exp.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", exp.kind, out_item.kind);
                    error_count++;
                end
                if (out_item.entry_addr !== exp.entry_addr) begin
                    $error("entry_addr mismatch: expected %h, actual %h",
                           exp.entry_addr, out_item.entry_addr);
                    error_count++;
                end
                if (out_item.page_size !== exp.page_size) begin
                    $error("page_size mismatch: expected %0d, actual %0d",
                           exp.page_size, out_item.page_size);
                    error_count++;
                end
            end
        end
    end

    // Hold valid high across a burst; open a random gap, at times none, before each new burst
    task automatic send_item(t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        expected_results.push_back(walk_step(it));
        item_count++;
    endtask

    task automatic send_start(logic [VADDR_W-1:0] va);
        t_in_item it;
        it           = '0;
        it.cmd       = CMD_START;
        it.vaddr     = va;
        it.read_data = rand64();
        send_item(it);
    endtask

    task automatic send_resp(logic [ADDR_W-1:0] data);
        t_in_item it;
        it           = '0;
        it.cmd       = CMD_RESP;
        it.vaddr     = rand_vaddr();
        it.read_data = data;
        send_item(it);
    endtask

    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_sel sel, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(sel) << REG_SEL_BIT);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_TABLE_ROOT) root_reg = value;
        else mask_reg = value;
    endtask

    task automatic maybe_busy_start();
        if ($urandom_range(0, 9) == 0) send_start(rand_vaddr());
    endtask

    task automatic run_walk(logic [VADDR_W-1:0] va, t_page_size sz);
        send_start(va);
        maybe_busy_start();
        send_resp(rand_entry());
        maybe_busy_start();
        send_resp(entry_with(sz == SIZE_1G));
        if (sz != SIZE_1G) begin
            maybe_busy_start();
            send_resp(entry_with(sz == SIZE_2M));
        end
    endtask

    // Mostly complete walks; the rest is loose items that break the sequence
    task automatic random_traffic(int unsigned n);
        int unsigned stop_at;
        int unsigned half_at;
        logic        paused;
        t_in_item    noise;
        stop_at = item_count + n;
        half_at = item_count + n / 2;
        paused  = 1'b0;
        while (item_count < stop_at) begin
            if (!paused && item_count >= half_at) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
                run_walk(rand_vaddr(), t_page_size'($urandom_range(0, 2)));
            end else begin
                noise.cmd       = t_cmd'($urandom_range(0, 1));
                noise.vaddr     = rand_vaddr();
                noise.read_data = rand_entry();
                send_item(noise);
            end
        end
        while (walk_lvl != LVL_IDLE) send_resp(rand_entry());
        drain_results();
    endtask

    task automatic test_idle_responses();
        send_resp('0);
        send_resp('1);
    endtask

    task automatic test_page_sizes();
        send_start('1);
        send_resp('1);
        send_resp('1);
        send_start('0);
        send_resp('0);
        send_resp('0);
        send_resp(64'h80);
        send_start(rand_vaddr());
        send_resp(rand64());
        send_resp(entry_with(1'b0));
        send_resp(entry_with(1'b0));
    endtask

    task automatic test_start_mid_walk();
        send_start(rand_vaddr());
        send_start(rand_vaddr());
        send_resp(rand64());
        send_start(rand_vaddr());
        send_resp(entry_with(1'b0));
        send_start(rand_vaddr());
        send_resp(entry_with(1'b1));
        drain_results();
    endtask

    task automatic test_random_walks();
        random_traffic(186);
    endtask

    task automatic test_register_settings();
        write_reg(REG_TABLE_ROOT, rand64());
        write_reg(REG_ENTRY_MASK, '1);
        random_traffic(186);
        write_reg(REG_TABLE_ROOT, '1);
        write_reg(REG_ENTRY_MASK, '0);
        random_traffic(186);
        write_reg(REG_TABLE_ROOT, '0);
        write_reg(REG_ENTRY_MASK, ENTRY_MASK_INIT);
        random_traffic(186);
        write_reg(REG_TABLE_ROOT, rand64());
        write_reg(REG_ENTRY_MASK, rand64());
        random_traffic(186);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_responses();
        test_page_sizes();
        test_start_mid_walk();
        test_random_walks();
        test_register_settings();
        drain_results();
        if (error_count == 0) begin
            $display("page_table_walker_top_tb: PASS");
        end else begin
            $display("page_table_walker_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- page_table_walker_top.f -----
src/pwt_pkg.sv
src/pwt_step.sv
src/page_table_walker_top.sv
src/pwt_checker.sv
tb/page_table_walker_top_tb.sv
